### hw/rtl/sobel_pkg.sv
package sobel_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_IMAGE_WIDTH    = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_EDGE_THRESHOLD = 2'd2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int THRESH_W    = 8;

    // Reset values of the registers
    localparam int RESET_WIDTH     = 640;
    localparam int RESET_HEIGHT    = 480;
    localparam int RESET_THRESHOLD = 50;

    // 16 * threshold^2 fits in 20 bits; gradient magnitude squared in 22
    localparam int LIM_W  = 20;
    localparam int GRAD_W = 11;
    localparam int MAG_W  = 22;

    localparam logic [7:0] WHITE_LEVEL = 8'd255;

    // Up to four result words per input word
    localparam int MAX_RESULTS = 4;
    localparam int SLOT_IDX_W  = 2;
    localparam int SLOT_CNT_W  = 3;

    // Pixel as it sits on the stream: red in the lowest byte
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    // One line store entry: the two previous rows at one column
    typedef struct packed {
        pixel_t upper;
        pixel_t middle;
    } line_pair_t;

    // Position flags of an item, worked out at acceptance
    typedef struct packed {
        logic col_ge1;
        logic col_ge2;
        logic row_ge1;
        logic row_ge2;
        logic last_col;
        logic last_row;
    } pos_flags_t;

    // One queued result word
    typedef struct packed {
        pixel_t pix;
        logic   frame_last;
    } result_t;

endpackage

### hw/rtl/sobel_line_store.sv
module sobel_line_store #(
    parameter int DEPTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [$clog2(DEPTH)-1:0]      rd_addr,
    input  logic                          wr_en,
    input  logic [$clog2(DEPTH)-1:0]      wr_addr,
    input  sobel_pkg::line_pair_t         wr_data,
    output sobel_pkg::line_pair_t         rd_data
);

    sobel_pkg::line_pair_t mem [DEPTH];
    sobel_pkg::line_pair_t rd_q_reg;
    sobel_pkg::line_pair_t fwd_data_reg;
    logic                  fwd_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read; holds while no new read is issued
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_q_reg     <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    // Flag a read that collides with a write in the same cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : rd_q_reg;

endmodule

### hw/rtl/sobel_edge_threshold.sv
// Channel   Direction  Word
// s_axis    in         pixel: tdata = in_red, in_green, in_blue
// m_axis    out        pixel: tdata = out_red, out_green, out_blue;
//                      tlast = run_last; tuser = frame_last
// cfg       in         register write: cfg_index, cfg_data
//
// One pixel is accepted per cycle while m_axis keeps up; a pixel with k results
// holds the output until all k are taken, so the output side sets the rate on
// the last column and row. Stage 1 forms the window and gradients, then stage 2
// does the magnitude compare into the result queue.
// Reset clears window, position and valids; line entries are always written
// before they reach a result. A stall on m_axis backs up stage by stage.
module sobel_edge_threshold #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [23:0]                        s_axis_tdata,  // in_red, in_green, in_blue
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [23:0]                        m_axis_tdata,  // out_red, out_green, out_blue
    output logic                               m_axis_tlast,
    output logic                               m_axis_tuser,  // frame_last
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sobel_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [sobel_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int SZW = (CW + 1 > sobel_pkg::CFG_DATA_W) ? CW + 1 : sobel_pkg::CFG_DATA_W;
    localparam int SZH = (RW + 1 > sobel_pkg::CFG_DATA_W) ? RW + 1 : sobel_pkg::CFG_DATA_W;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [SZW-1:0]                  width_reg;
    logic [SZH-1:0]                  height_reg;
    logic [sobel_pkg::LIM_W-1:0]     lim_reg;
    logic [SZW-1:0]                  cfg_w;
    logic [SZH-1:0]                  cfg_h;
    logic [sobel_pkg::THRESH_W-1:0]  cfg_t;
    logic                            cfg_fire;
    logic                            size_write;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign cfg_t     = cfg_data[sobel_pkg::THRESH_W-1:0];
    assign size_write = cfg_fire && ((cfg_index == sobel_pkg::REG_IMAGE_WIDTH)
                                  || (cfg_index == sobel_pkg::REG_IMAGE_HEIGHT));

    // Clamp size writes to 1..MAX
    always_comb
    begin
        cfg_w = SZW'(cfg_data);
        if (cfg_w == '0)
        begin
            cfg_w = SZW'(1);
        end
        if (cfg_w > SZW'(MAX_WIDTH))
        begin
            cfg_w = SZW'(MAX_WIDTH);
        end
        cfg_h = SZH'(cfg_data);
        if (cfg_h == '0)
        begin
            cfg_h = SZH'(1);
        end
        if (cfg_h > SZH'(MAX_HEIGHT))
        begin
            cfg_h = SZH'(MAX_HEIGHT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SZW'(sobel_pkg::RESET_WIDTH);
            height_reg <= SZH'(sobel_pkg::RESET_HEIGHT);
            lim_reg    <= sobel_pkg::LIM_W'(16 * sobel_pkg::RESET_THRESHOLD
                                                * sobel_pkg::RESET_THRESHOLD);
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index)
                sobel_pkg::REG_IMAGE_WIDTH:    width_reg  <= cfg_w;
                sobel_pkg::REG_IMAGE_HEIGHT:   height_reg <= cfg_h;
                sobel_pkg::REG_EDGE_THRESHOLD:
                    lim_reg <= sobel_pkg::LIM_W'({16'(cfg_t) * 16'(cfg_t), 4'b0000});
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage handshakes
    // ------------------------------------------------------------------
    logic                          s1_valid_reg;
    logic                          s2_valid_reg;
    logic                          b_valid_reg;
    logic                          s1_go;
    logic                          s1_free;
    logic                          s2_go;
    logic                          s2_free;
    logic                          load_b;
    logic                          b_done;
    logic                          out_fire;
    logic                          accept;
    logic [sobel_pkg::SLOT_CNT_W-1:0] s2_cnt;
    logic [sobel_pkg::SLOT_CNT_W-1:0] b_cnt_reg;
    logic [sobel_pkg::SLOT_IDX_W-1:0] b_idx_reg;

    assign out_fire = m_axis_tvalid && m_axis_tready;
    assign b_done   = out_fire
                      && (sobel_pkg::SLOT_CNT_W'(b_idx_reg) + 1'b1 == b_cnt_reg);
    assign load_b   = !b_valid_reg || b_done;
    assign s2_go    = s2_valid_reg && ((s2_cnt == '0) || load_b);
    assign s2_free  = !s2_valid_reg || s2_go;
    assign s1_go    = s1_valid_reg && s2_free;
    assign s1_free  = !s1_valid_reg || s1_go;
    assign s_axis_tready = s1_free;
    assign accept   = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // Position counters and acceptance
    // ------------------------------------------------------------------
    logic [CW-1:0]         col_reg;
    logic [RW-1:0]         row_reg;
    sobel_pkg::pos_flags_t pos;

    assign pos.col_ge1  = (col_reg != '0);
    assign pos.col_ge2  = (col_reg >= CW'(2));
    assign pos.row_ge1  = (row_reg != '0);
    assign pos.row_ge2  = (row_reg >= RW'(2));
    assign pos.last_col = (SZW'(col_reg) + SZW'(1) == width_reg);
    assign pos.last_row = (SZH'(row_reg) + SZH'(1) == height_reg);

    // Advance raster position; a size write restarts the frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (size_write)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            if (pos.last_col)
            begin
                col_reg <= '0;
                row_reg <= pos.last_row ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: line store data arrives, window shifts, gradients form
    // ------------------------------------------------------------------
    sobel_pkg::pixel_t     s1_pix_reg;
    logic [CW-1:0]         s1_addr_reg;
    sobel_pkg::pos_flags_t s1_pos_reg;
    sobel_pkg::line_pair_t line_rd;
    sobel_pkg::line_pair_t line_wr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_free)
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg  <= sobel_pkg::pixel_t'(s_axis_tdata);
            s1_addr_reg <= col_reg;
            s1_pos_reg  <= pos;
        end
    end

    // Shift the column down the lines: middle moves to upper, pixel to middle
    assign line_wr.upper  = line_rd.middle;
    assign line_wr.middle = s1_pix_reg;

    sobel_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .wr_en   (s1_go),
        .wr_addr (s1_addr_reg),
        .wr_data (line_wr),
        .rd_data (line_rd)
    );

    sobel_pkg::pixel_t win_reg  [9];
    sobel_pkg::pixel_t win_next [9];

    // Shift the window one column left and take the new column
    always_comb
    begin
        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[2] = line_rd.upper;
        win_next[3] = win_reg[4];
        win_next[4] = win_reg[5];
        win_next[5] = line_rd.middle;
        win_next[6] = win_reg[7];
        win_next[7] = win_reg[8];
        win_next[8] = s1_pix_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (s1_go)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= win_next[i];
            end
        end
    end

    logic signed [sobel_pkg::GRAD_W-1:0] bl [9];
    logic signed [sobel_pkg::GRAD_W-1:0] gx_next;
    logic signed [sobel_pkg::GRAD_W-1:0] gy_next;

    // Sobel kernels on blue
    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            bl[i] = $signed({3'b000, win_next[i].blue});
        end
        gx_next = bl[2] + (bl[5] <<< 1) + bl[8] - bl[0] - (bl[3] <<< 1) - bl[6];
        gy_next = bl[6] + (bl[7] <<< 1) + bl[8] - bl[0] - (bl[1] <<< 1) - bl[2];
    end

    // ------------------------------------------------------------------
    // Stage 2: magnitude compare and result list
    // ------------------------------------------------------------------
    logic signed [sobel_pkg::GRAD_W-1:0] s2_gx_reg;
    logic signed [sobel_pkg::GRAD_W-1:0] s2_gy_reg;
    sobel_pkg::pixel_t                   s2_p4_reg;
    sobel_pkg::pixel_t                   s2_p5_reg;
    sobel_pkg::pixel_t                   s2_p7_reg;
    sobel_pkg::pixel_t                   s2_p8_reg;
    sobel_pkg::pos_flags_t               s2_pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_free)
        begin
            s2_valid_reg <= s1_go;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            s2_gx_reg  <= gx_next;
            s2_gy_reg  <= gy_next;
            s2_p4_reg  <= win_next[4];
            s2_p5_reg  <= win_next[5];
            s2_p7_reg  <= win_next[7];
            s2_p8_reg  <= win_next[8];
            s2_pos_reg <= s1_pos_reg;
        end
    end

    logic signed [2*sobel_pkg::GRAD_W-1:0] sq_x;
    logic signed [2*sobel_pkg::GRAD_W-1:0] sq_y;
    logic [sobel_pkg::MAG_W-1:0]           mag;
    sobel_pkg::pixel_t                     edge_pix;
    sobel_pkg::pixel_t                     first_pix;
    sobel_pkg::result_t                    cand  [sobel_pkg::MAX_RESULTS];
    logic [sobel_pkg::MAX_RESULTS-1:0]     cand_en;
    sobel_pkg::result_t                    slot_next [sobel_pkg::MAX_RESULTS];

    assign sq_x = s2_gx_reg * s2_gx_reg;
    assign sq_y = s2_gy_reg * s2_gy_reg;
    assign mag  = sobel_pkg::MAG_W'(unsigned'(sq_x)) + sobel_pkg::MAG_W'(unsigned'(sq_y));

    always_comb
    begin
        if (mag > sobel_pkg::MAG_W'(lim_reg))
        begin
            edge_pix = '{blue: sobel_pkg::WHITE_LEVEL, green: sobel_pkg::WHITE_LEVEL,
                         red: sobel_pkg::WHITE_LEVEL};
        end
        else
        begin
            edge_pix = '0;
        end
    end

    // Interior pixels get the edge decision, borders pass through
    assign first_pix = (s2_pos_reg.row_ge2 && s2_pos_reg.col_ge2) ? edge_pix : s2_p4_reg;

    // Candidates in output order: center, bottom-middle, middle-right, bottom-right
    always_comb
    begin
        cand[0] = '{pix: first_pix, frame_last: 1'b0};
        cand[1] = '{pix: s2_p7_reg, frame_last: 1'b0};
        cand[2] = '{pix: s2_p5_reg, frame_last: 1'b0};
        cand[3] = '{pix: s2_p8_reg, frame_last: 1'b1};
        cand_en[0] = s2_pos_reg.row_ge1  && s2_pos_reg.col_ge1;
        cand_en[1] = s2_pos_reg.last_row && s2_pos_reg.col_ge1;
        cand_en[2] = s2_pos_reg.row_ge1  && s2_pos_reg.last_col;
        cand_en[3] = s2_pos_reg.last_row && s2_pos_reg.last_col;
    end

    // Pack the enabled candidates into consecutive slots
    always_comb
    begin
        s2_cnt = '0;
        for (int i = 0; i < sobel_pkg::MAX_RESULTS; i++)
        begin
            slot_next[i] = cand[i];
        end
        for (int i = 0; i < sobel_pkg::MAX_RESULTS; i++)
        begin
            if (cand_en[i])
            begin
                slot_next[s2_cnt[sobel_pkg::SLOT_IDX_W-1:0]] = cand[i];
                s2_cnt = s2_cnt + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result queue: while m_axis_tready holds, drain one word per cycle
    // ------------------------------------------------------------------
    sobel_pkg::result_t slot_reg [sobel_pkg::MAX_RESULTS];
    logic               b_load;

    assign b_load = s2_go && (s2_cnt != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            b_cnt_reg   <= '0;
            b_idx_reg   <= '0;
        end
        else
        begin
            priority if (b_load)
            begin
                b_valid_reg <= 1'b1;
                b_cnt_reg   <= s2_cnt;
                b_idx_reg   <= '0;
            end
            else if (b_done)
            begin
                b_valid_reg <= 1'b0;
            end
            else if (out_fire)
            begin
                b_idx_reg <= b_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_load)
        begin
            for (int i = 0; i < sobel_pkg::MAX_RESULTS; i++)
            begin
                slot_reg[i] <= slot_next[i];
            end
        end
    end

    assign m_axis_tvalid = b_valid_reg;
    assign m_axis_tdata  = slot_reg[b_idx_reg].pix;
    assign m_axis_tuser  = slot_reg[b_idx_reg].frame_last;
    assign m_axis_tlast  = (sobel_pkg::SLOT_CNT_W'(b_idx_reg) + 1'b1 == b_cnt_reg);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> (sobel_pkg::SLOT_CNT_W'(b_idx_reg) < b_cnt_reg))
        else $error("result index beyond queued count");

    a_frame_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
        else $error("frame end not on last word of its run");

    a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        SZW'(col_reg) < width_reg)
        else $error("column position outside configured width");

    a_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        SZH'(row_reg) < height_reg)
        else $error("row position outside configured height");

    a_queue_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && out_fire && !m_axis_tlast) |=> (b_valid_reg
            && b_idx_reg == $past(b_idx_reg) + 1'b1))
        else $error("result queue did not step after a taken word");

endmodule

### sim/tb_sobel_edge_threshold.sv
module tb_sobel_edge_threshold;

    localparam int MAX_W        = 1024;
    localparam int MAX_H        = 1024;
    localparam int RANDOM_ITEMS = 250;
    localparam int EDGE_RUN     = 40;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT  = 1000;

    // Index that selects no register
    localparam logic [sobel_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum {PIX_FULL, PIX_EXTREME, PIX_STEP} pix_style_t;

    // One expected output word
    typedef struct packed {
        sobel_pkg::pixel_t pix;
        logic              run_last;
        logic              frame_last;
    } edge_word_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [23:0]                       s_axis_tdata = '0;   // in_red, in_green, in_blue
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [23:0]                       m_axis_tdata;        // out_red, out_green, out_blue
    logic                              m_axis_tlast;
    logic                              m_axis_tuser;        // frame_last
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [sobel_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [sobel_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    sobel_edge_threshold #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Shadow of the block: line stores, window, position and registers
    sobel_pkg::pixel_t top_line [MAX_W];
    sobel_pkg::pixel_t mid_line [MAX_W];
    sobel_pkg::pixel_t kernel_win [9];
    int                col_at;
    int                row_at;
    int                frame_w;
    int                frame_h;
    int                edge_thr;
    edge_word_t        edge_pixels_due [$];

    sobel_pkg::pixel_t pixel_q [$];
    int                src_gap = 0;
    int                src_stretch = 0;
    bit                src_calm = 1'b0;
    int                snk_gap = 0;
    int                snk_stretch = 0;
    bit                snk_calm = 1'b0;
    int                quiet_cycles = 0;

    int                pixels_in = 0;
    int                words_out = 0;
    int                cfg_writes = 0;
    int                mismatch_count = 0;

    function automatic void shadow_reset();
        frame_w  = sobel_pkg::RESET_WIDTH;
        frame_h  = sobel_pkg::RESET_HEIGHT;
        edge_thr = sobel_pkg::RESET_THRESHOLD;
        col_at   = 0;
        row_at   = 0;
        for (int k = 0; k < MAX_W; k++)
        begin
            top_line[k] = '0;
            mid_line[k] = '0;
        end
        for (int k = 0; k < 9; k++)
            kernel_win[k] = '0;
    endfunction

    function automatic int clamp_dim(input logic [sobel_pkg::CFG_DATA_W-1:0] v,
                                     input int maxv);
        int s;
        s = int'(v);
        if (s == 0)
            s = 1;
        if (s > maxv)
            s = maxv;
        return s;
    endfunction

    function automatic void shadow_config(input logic [sobel_pkg::CFG_INDEX_W-1:0] idx,
                                          input logic [sobel_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            sobel_pkg::REG_IMAGE_WIDTH:
            begin
                frame_w = clamp_dim(val, MAX_W);
                col_at  = 0;
                row_at  = 0;
            end
            sobel_pkg::REG_IMAGE_HEIGHT:
            begin
                frame_h = clamp_dim(val, MAX_H);
                col_at  = 0;
                row_at  = 0;
            end
            sobel_pkg::REG_EDGE_THRESHOLD:
                edge_thr = int'(val[sobel_pkg::THRESH_W-1:0]);
            default:
                ;
        endcase
    endfunction

    function automatic int blue_at(input int k);
        return int'(kernel_win[k].blue);
    endfunction

    // Gradient magnitude squared against sixteen times threshold squared
    function automatic sobel_pkg::pixel_t sobel_edge();
        int gx;
        int gy;
        int lim;
        gx = blue_at(2) - blue_at(0) + 2 * (blue_at(5) - blue_at(3))
           + blue_at(8) - blue_at(6);
        gy = blue_at(6) + 2 * blue_at(7) + blue_at(8)
           - blue_at(0) - 2 * blue_at(1) - blue_at(2);
        lim = 16 * edge_thr * edge_thr;
        if (gx * gx + gy * gy > lim)
            return '{blue: sobel_pkg::WHITE_LEVEL, green: sobel_pkg::WHITE_LEVEL,
                     red: sobel_pkg::WHITE_LEVEL};
        return '0;
    endfunction

    // Advance the shadow by one pixel and queue the words it releases
    task automatic sobel_predict(input sobel_pkg::pixel_t px);
        int         c;
        int         r;
        int         k;
        bit         end_col;
        bit         end_row;
        edge_word_t burst [$];
        c = col_at;
        r = row_at;
        if (c >= frame_w || c >= MAX_W)
            c = 0;
        if (r >= frame_h)
            r = 0;
        end_col = (c + 1 == frame_w);
        end_row = (r + 1 == frame_h);

        for (k = 0; k < 3; k++)
        begin
            kernel_win[k * 3]     = kernel_win[k * 3 + 1];
            kernel_win[k * 3 + 1] = kernel_win[k * 3 + 2];
        end
        kernel_win[2] = top_line[c];
        kernel_win[5] = mid_line[c];
        kernel_win[8] = px;
        top_line[c]   = mid_line[c];
        mid_line[c]   = px;

        // Row above first, then the last row interleaved, then the flushes
        if (r >= 1 && c >= 1)
            burst.push_back('{pix: (r >= 2 && c >= 2) ? sobel_edge() : kernel_win[4],
                              run_last: 1'b0, frame_last: 1'b0});
        if (end_row && c >= 1)
            burst.push_back('{pix: kernel_win[7], run_last: 1'b0, frame_last: 1'b0});
        if (r >= 1 && end_col)
            burst.push_back('{pix: kernel_win[5], run_last: 1'b0, frame_last: 1'b0});
        if (end_row && end_col)
            burst.push_back('{pix: kernel_win[8], run_last: 1'b0, frame_last: 1'b1});
        if (burst.size() != 0)
            burst[burst.size() - 1].run_last = 1'b1;
        for (k = 0; k < burst.size(); k++)
            edge_pixels_due.push_back(burst[k]);

        c++;
        if (c >= frame_w)
        begin
            c = 0;
            r++;
            if (r >= frame_h)
                r = 0;
        end
        col_at = c;
        row_at = r;
    endtask

    function automatic int pick_gap(input bit calm);
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic sobel_pkg::pixel_t make_pixel(input pix_style_t style);
        sobel_pkg::pixel_t p;
        p.red   = 8'($urandom_range(0, 255));
        p.green = 8'($urandom_range(0, 255));
        case (style)
            PIX_EXTREME:
            begin
                p.red   = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                p.green = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                p.blue  = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            end
            PIX_STEP:
                p.blue = $urandom_range(0, 1) ? 8'($urandom_range(225, 255))
                                              : 8'($urandom_range(0, 30));
            default:
                p.blue = 8'($urandom_range(0, 255));
        endcase
        return p;
    endfunction

    function automatic logic [sobel_pkg::CFG_DATA_W-1:0] pick_threshold();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return 11'd255;
        if (roll == 2)
            return sobel_pkg::CFG_DATA_W'($urandom_range(0, 2047));
        return sobel_pkg::CFG_DATA_W'($urandom_range(0, 255));
    endfunction

    // Source side: feed pixel words from the pending queue with random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            src_gap       <= 0;
        end
        else
        begin
            if (src_stretch == 0)
            begin
                src_stretch <= $urandom_range(10, 80);
                src_calm    <= ($urandom_range(0, 3) == 0);
            end
            else
                src_stretch <= src_stretch - 1;

            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (src_gap != 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    src_gap       <= src_gap - 1;
                end
                else if (pixel_q.size() != 0)
                begin
                    s_axis_tdata  <= pixel_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    src_gap       <= pick_gap(src_calm);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Sink side: stall after a word now and then
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            snk_gap       <= 0;
        end
        else
        begin
            if (snk_stretch == 0)
            begin
                snk_stretch <= $urandom_range(10, 80);
                snk_calm    <= ($urandom_range(0, 3) == 0);
            end
            else
                snk_stretch <= snk_stretch - 1;

            if (snk_gap != 0)
            begin
                m_axis_tready <= 1'b0;
                snk_gap       <= snk_gap - 1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (m_axis_tvalid && m_axis_tready)
                    snk_gap <= pick_gap(snk_calm);
            end
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Predict on each accepted pixel, compare each accepted result word
    always @(posedge clk)
    begin : monitor
        edge_word_t        want;
        sobel_pkg::pixel_t got;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                sobel_predict(sobel_pkg::pixel_t'(s_axis_tdata));
                pixels_in++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                words_out++;
                got = sobel_pkg::pixel_t'(m_axis_tdata);
                if (edge_pixels_due.size() == 0)
                begin
                    $error("result word with none expected: tdata %06h", m_axis_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = edge_pixels_due.pop_front();
                    check_field("out_red", want.pix.red, got.red);
                    check_field("out_green", want.pix.green, got.green);
                    check_field("out_blue", want.pix.blue, got.blue);
                    check_field("run_last", want.run_last, m_axis_tlast);
                    check_field("frame_last", want.frame_last, m_axis_tuser);
                end
            end
        end
    end

    // Count cycles without any accepted word
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // Call on a rising edge; returns on a rising edge
    task automatic write_reg(input logic [sobel_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [sobel_pkg::CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        shadow_config(idx, val);
        cfg_writes++;
        @(posedge clk);
    endtask

    task automatic queue_pixels(input int n, input pix_style_t style);
        @(negedge clk);
        for (int k = 0; k < n; k++)
            pixel_q.push_back(make_pixel(style));
    endtask

    // Wait until every queued pixel is sent and every word is back, then let the pipe settle
    task automatic wait_drain();
        do
            @(negedge clk);
        while (pixel_q.size() != 0 || s_axis_tvalid || edge_pixels_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int                w;
        int                h;
        int                n;
        int                frame_px;
        int                random_pixels;
        bit                partial;
        sobel_pkg::pixel_t p;
        pix_style_t        style;

        shadow_reset();
        random_pixels = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Small frame of extreme pixels, any gradient turns white
        write_reg(sobel_pkg::REG_EDGE_THRESHOLD, '0);
        write_reg(sobel_pkg::REG_IMAGE_WIDTH, 11'd4);
        write_reg(sobel_pkg::REG_IMAGE_HEIGHT, 11'd3);
        queue_pixels(12, PIX_EXTREME);
        wait_drain();

        // Zero sizes fall back to a single pixel frame
        write_reg(sobel_pkg::REG_IMAGE_WIDTH, '0);
        write_reg(sobel_pkg::REG_IMAGE_HEIGHT, '0);
        queue_pixels(3, PIX_FULL);
        wait_drain();

        // Unused index, top threshold with high data bits set, strongest corner edge
        write_reg(REG_UNUSED, 11'h7FF);
        write_reg(sobel_pkg::REG_EDGE_THRESHOLD, 11'h7FF);
        write_reg(sobel_pkg::REG_IMAGE_WIDTH, 11'd3);
        write_reg(sobel_pkg::REG_IMAGE_HEIGHT, 11'd3);
        @(negedge clk);
        for (int k = 0; k < 9; k++)
        begin
            p = make_pixel(PIX_FULL);
            p.blue = (k == 0 || k == 1 || k == 3) ? 8'd0 : 8'd255;
            pixel_q.push_back(p);
        end
        wait_drain();

        // Start of the widest row, then start of the tallest column with an oversized height
        write_reg(sobel_pkg::REG_EDGE_THRESHOLD, pick_threshold());
        write_reg(sobel_pkg::REG_IMAGE_WIDTH, 11'd1024);
        write_reg(sobel_pkg::REG_IMAGE_HEIGHT, 11'd1);
        queue_pixels(EDGE_RUN, PIX_STEP);
        wait_drain();
        write_reg(sobel_pkg::REG_IMAGE_WIDTH, 11'd1);
        write_reg(sobel_pkg::REG_IMAGE_HEIGHT, 11'h7FF);
        queue_pixels(EDGE_RUN, PIX_FULL);
        wait_drain();

        // Oversized width, a few first-row pixels, then restart on the next size write
        write_reg(sobel_pkg::REG_IMAGE_HEIGHT, 11'd2);
        write_reg(sobel_pkg::REG_IMAGE_WIDTH, 11'h7FF);
        queue_pixels(3, PIX_FULL);
        wait_drain();

        // Random frames, some cut short by a size write, some with a threshold change mid-frame
        while (random_pixels < RANDOM_ITEMS)
        begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
            if ($urandom_range(0, 1))
            begin
                write_reg(sobel_pkg::REG_IMAGE_WIDTH, sobel_pkg::CFG_DATA_W'(w));
                write_reg(sobel_pkg::REG_IMAGE_HEIGHT, sobel_pkg::CFG_DATA_W'(h));
            end
            else
            begin
                write_reg(sobel_pkg::REG_IMAGE_HEIGHT, sobel_pkg::CFG_DATA_W'(h));
                write_reg(sobel_pkg::REG_IMAGE_WIDTH, sobel_pkg::CFG_DATA_W'(w));
            end
            if ($urandom_range(0, 1))
                write_reg(sobel_pkg::REG_EDGE_THRESHOLD, pick_threshold());
            if ($urandom_range(0, 15) == 0)
                write_reg(REG_UNUSED, sobel_pkg::CFG_DATA_W'($urandom_range(0, 2047)));

            frame_px = w * h;
            partial  = ($urandom_range(0, 3) == 0);
            n = partial ? $urandom_range(1, frame_px) : frame_px * $urandom_range(1, 2);
            if (n > RANDOM_ITEMS - random_pixels)
                n = RANDOM_ITEMS - random_pixels;
            style = pix_style_t'($urandom_range(0, 2));
            queue_pixels(n, style);
            wait_drain();
            random_pixels += n;

            // Change the threshold mid-frame and finish the frame
            if (partial && n < frame_px && random_pixels + frame_px - n <= RANDOM_ITEMS
                && $urandom_range(0, 1))
            begin
                write_reg(sobel_pkg::REG_EDGE_THRESHOLD, pick_threshold());
                queue_pixels(frame_px - n, style);
                wait_drain();
                random_pixels += frame_px - n;
            end
        end

        wait_drain();
        $display("Streamed %0d pixels and checked %0d result words over %0d register writes,",
                 pixels_in, words_out, cfg_writes);
        $display("frame sizes from one pixel to the largest setting, thresholds from zero to top.");
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### sobel_edge_threshold.f
hw/rtl/sobel_pkg.sv
hw/rtl/sobel_line_store.sv
hw/rtl/sobel_edge_threshold.sv
sim/tb_sobel_edge_threshold.sv
